// ===== hw/rtl/sepc_pkg.sv =====
// Shared types, constants and signature tables for the SMBIOS entry point checker.
package sepc_pkg;

    // Request queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Byte counter saturates at this value
    localparam int          IDX_W   = 9;
    localparam logic [8:0]  IDX_SAT = 9'd256;

    // Result form codes
    localparam logic [1:0] FORM_NONE = 2'd0;
    localparam logic [1:0] FORM_V21  = 2'd1;
    localparam logic [1:0] FORM_V30  = 2'd2;

    // Signature lengths
    localparam logic [7:0] SIG3_LEN = 8'd5;
    localparam logic [7:0] SIG2_LEN = 8'd4;

    // 3.0 form offsets
    localparam logic [7:0] V30_LEN_OFS   = 8'h06;
    localparam logic [7:0] V30_MAJOR_OFS = 8'h07;
    localparam logic [7:0] V30_MINOR_OFS = 8'h08;
    localparam logic [7:0] V30_SIZE_OFS  = 8'h0C;
    localparam logic [7:0] V30_ADDR_OFS  = 8'h10;
    localparam logic [7:0] V30_ADDR_END  = 8'h18;
    localparam logic [7:0] V30_MIN_LEN   = 8'h18;

    // 2.1 form offsets
    localparam logic [7:0] V21_LEN_OFS   = 8'h05;
    localparam logic [7:0] V21_MAJOR_OFS = 8'h06;
    localparam logic [7:0] V21_MINOR_OFS = 8'h07;
    localparam logic [7:0] V21_SIZE_OFS  = 8'h16;
    localparam logic [7:0] V21_ADDR_OFS  = 8'h18;
    localparam logic [7:0] V21_ADDR_END  = 8'h1C;
    localparam logic [7:0] V21_MIN_LEN   = 8'h1E;
    localparam logic [8:0] V21_MIN_AVAIL = 9'h01F;

    // Intermediate (_DMI_) area of the 2.1 form
    localparam logic [7:0] DMI_OFS     = 8'h10;
    localparam logic [7:0] DMI_SIG_END = 8'h15;
    localparam logic [7:0] DMI_SUM_END = 8'h1F;

    // One classified byte request
    typedef struct packed {
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic             take;
        logic             last;
        logic             sig3_miss;
        logic             sig2_miss;
        logic             dmi_miss;
        logic             dmi_add;
    } t_item;

    // "_SM3_"
    function automatic logic [7:0] sig3_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h5F;
            3'd1:    ch = 8'h53;
            3'd2:    ch = 8'h4D;
            3'd3:    ch = 8'h33;
            3'd4:    ch = 8'h5F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "_SM_"
    function automatic logic [7:0] sig2_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h5F;
            2'd1:    ch = 8'h53;
            2'd2:    ch = 8'h4D;
            default: ch = 8'h5F;
        endcase
        return ch;
    endfunction

    // "_DMI_"
    function automatic logic [7:0] dmi_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h5F;
            3'd1:    ch = 8'h44;
            3'd2:    ch = 8'h4D;
            3'd3:    ch = 8'h49;
            3'd4:    ch = 8'h5F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/sepc_front.sv =====
// Front end: accepts byte requests, tracks the byte index and classifies signature bytes.
module sepc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_entry_byte,
    input  logic                 i_last_byte,
    input  logic                 i_full,
    output logic                 o_stall,
    output logic                 o_push,
    output sepc_pkg::t_item      o_item
);

    logic [sepc_pkg::IDX_W-1:0] r_index;
    logic [sepc_pkg::IDX_W-1:0] n_index;
    logic                       w_take;
    logic [7:0]                 w_idx8;
    logic [7:0]                 w_dmi_ofs;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    assign w_take    = !r_index[8];
    assign w_idx8    = r_index[7:0];
    assign w_dmi_ofs = w_idx8 - sepc_pkg::DMI_OFS;

    // Classify the byte against the signatures at its position
    always_comb begin
        o_item.data      = i_entry_byte;
        o_item.idx       = r_index;
        o_item.take      = w_take;
        o_item.last      = i_last_byte;
        o_item.sig3_miss = w_take && (w_idx8 < sepc_pkg::SIG3_LEN)
                           && (i_entry_byte != sepc_pkg::sig3_char(w_idx8[2:0]));
        o_item.sig2_miss = w_take && (w_idx8 < sepc_pkg::SIG2_LEN)
                           && (i_entry_byte != sepc_pkg::sig2_char(w_idx8[1:0]));
        o_item.dmi_miss  = w_take && (w_idx8 >= sepc_pkg::DMI_OFS)
                           && (w_idx8 < sepc_pkg::DMI_SIG_END)
                           && (i_entry_byte != sepc_pkg::dmi_char(w_dmi_ofs[2:0]));
        o_item.dmi_add   = w_take && (w_idx8 >= sepc_pkg::DMI_OFS)
                           && (w_idx8 < sepc_pkg::DMI_SUM_END);
    end

    // Byte index: saturates, restarts after the final byte
    always_comb begin
        n_index = r_index;
        if (o_push) begin
            if (i_last_byte) begin
                n_index = '0;
            end else if (w_take) begin
                n_index = r_index + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

endmodule

// ===== hw/rtl/sepc_queue.sv =====
// Short request queue between the front end and the back end.
module sepc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sepc_pkg::t_item      i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output sepc_pkg::t_item      o_head
);

    sepc_pkg::t_item                r_slot [sepc_pkg::QDEPTH];
    logic [sepc_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [sepc_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [sepc_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == sepc_pkg::QCNT_W'(sepc_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == sepc_pkg::QPTR_W'(sepc_pkg::QDEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == sepc_pkg::QPTR_W'(sepc_pkg::QDEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

endmodule

// ===== hw/rtl/sepc_back.sv =====
// Back end: runs checksums and field capture, and registers the result of each candidate.
module sepc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  sepc_pkg::t_item      i_head,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic                 o_entry_ok,
    output logic [1:0]           o_entry_form,
    output logic [7:0]           o_spec_major,
    output logic [7:0]           o_spec_minor,
    output logic [31:0]          o_table_size,
    output logic [63:0]          o_table_address
);

    // Candidate state
    logic        r_sig3, n_sig3;
    logic        r_sig2, n_sig2;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_len, n_len;
    logic        r_sum_zero, n_sum_zero;
    logic [7:0]  r_dmi_sum, n_dmi_sum;
    logic        r_dmi_ok, n_dmi_ok;
    logic [7:0]  r_major, n_major;
    logic [7:0]  r_minor, n_minor;
    logic [31:0] r_size, n_size;
    logic [63:0] r_addr, n_addr;

    // Result register
    logic        r_out_valid;
    logic        r_ok, n_ok;
    logic [1:0]  r_form, n_form;
    logic [7:0]  r_out_major;
    logic [7:0]  r_out_minor;
    logic [31:0] r_out_size;
    logic [63:0] r_out_addr;

    logic [7:0]  w_idx8;
    logic [8:0]  w_avail;
    logic        w_f3;
    logic        w_f2;
    logic        w_fields_nz;
    logic        w_len_fits;

    // A final byte waits while the result register is still held
    assign o_pop = i_q_valid && (!i_head.last || !r_out_valid || !i_stall);

    assign w_idx8  = i_head.idx[7:0];
    assign w_avail = i_head.take ? (i_head.idx + 9'd1) : sepc_pkg::IDX_SAT;

    // Per-byte state update
    always_comb begin
        n_sig3     = r_sig3;
        n_sig2     = r_sig2;
        n_sum      = r_sum;
        n_len      = r_len;
        n_sum_zero = r_sum_zero;
        n_dmi_sum  = r_dmi_sum;
        n_dmi_ok   = r_dmi_ok;
        n_major    = r_major;
        n_minor    = r_minor;
        n_size     = r_size;
        n_addr     = r_addr;
        w_f3       = r_sig3 && !i_head.sig3_miss;
        w_f2       = r_sig2 && !i_head.sig2_miss;
        if (i_head.take) begin
            n_sig3 = w_f3;
            n_sig2 = w_f2;
            n_sum  = r_sum + i_head.data;
            // 3.0 form fields
            if (w_f3) begin
                if (w_idx8 == sepc_pkg::V30_LEN_OFS) begin
                    n_len = i_head.data;
                end else if (w_idx8 == sepc_pkg::V30_MAJOR_OFS) begin
                    n_major = i_head.data;
                end else if (w_idx8 == sepc_pkg::V30_MINOR_OFS) begin
                    n_minor = i_head.data;
                end else if (w_idx8 >= sepc_pkg::V30_SIZE_OFS
                             && w_idx8 < sepc_pkg::V30_ADDR_OFS) begin
                    n_size[{w_idx8[1:0], 3'b000} +: 8] = i_head.data;
                end else if (w_idx8 >= sepc_pkg::V30_ADDR_OFS
                             && w_idx8 < sepc_pkg::V30_ADDR_END) begin
                    n_addr[{w_idx8[2:0], 3'b000} +: 8] = i_head.data;
                end
            end
            // 2.1 form fields
            if (w_f2) begin
                if (w_idx8 == sepc_pkg::V21_LEN_OFS) begin
                    n_len = i_head.data;
                end else if (w_idx8 == sepc_pkg::V21_MAJOR_OFS) begin
                    n_major = i_head.data;
                end else if (w_idx8 == sepc_pkg::V21_MINOR_OFS) begin
                    n_minor = i_head.data;
                end else if (w_idx8 >= sepc_pkg::V21_SIZE_OFS
                             && w_idx8 < sepc_pkg::V21_ADDR_OFS) begin
                    n_size[{w_idx8[0], 3'b000} +: 8] = i_head.data;
                end else if (w_idx8 >= sepc_pkg::V21_ADDR_OFS
                             && w_idx8 < sepc_pkg::V21_ADDR_END) begin
                    n_addr[{w_idx8[1:0], 3'b000} +: 8] = i_head.data;
                end
            end
            // intermediate area
            if (i_head.dmi_miss) begin
                n_dmi_ok = 1'b0;
            end
            if (i_head.dmi_add) begin
                n_dmi_sum = r_dmi_sum + i_head.data;
            end
            // main checksum latched at the end of the declared length
            if ((i_head.idx + 9'd1) == {1'b0, n_len}) begin
                n_sum_zero = (n_sum == 8'd0);
            end
        end
    end

    // Result decision on the final byte
    always_comb begin
        w_fields_nz = (n_size != '0) && (n_addr != '0);
        w_len_fits  = ({1'b0, n_len} <= w_avail) && n_sum_zero;
        n_form      = sepc_pkg::FORM_NONE;
        n_ok        = 1'b0;
        if (n_sig3 && w_avail >= 9'({1'b0, sepc_pkg::SIG3_LEN})) begin
            n_form = sepc_pkg::FORM_V30;
            n_ok   = (w_avail >= {1'b0, sepc_pkg::V30_MIN_LEN})
                     && (n_len >= sepc_pkg::V30_MIN_LEN)
                     && w_len_fits && w_fields_nz;
        end else if (n_sig2 && w_avail >= 9'({1'b0, sepc_pkg::SIG2_LEN})) begin
            n_form = sepc_pkg::FORM_V21;
            n_ok   = (w_avail >= sepc_pkg::V21_MIN_AVAIL)
                     && (n_len >= sepc_pkg::V21_MIN_LEN)
                     && w_len_fits && n_dmi_ok && (n_dmi_sum == 8'd0)
                     && w_fields_nz;
        end
    end

    // Candidate state registers; cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_head.last)) begin
            r_sig3     <= 1'b1;
            r_sig2     <= 1'b1;
            r_sum      <= '0;
            r_len      <= '0;
            r_sum_zero <= 1'b0;
            r_dmi_sum  <= '0;
            r_dmi_ok   <= 1'b1;
            r_major    <= '0;
            r_minor    <= '0;
            r_size     <= '0;
            r_addr     <= '0;
        end else if (o_pop) begin
            r_sig3     <= n_sig3;
            r_sig2     <= n_sig2;
            r_sum      <= n_sum;
            r_len      <= n_len;
            r_sum_zero <= n_sum_zero;
            r_dmi_sum  <= n_dmi_sum;
            r_dmi_ok   <= n_dmi_ok;
            r_major    <= n_major;
            r_minor    <= n_minor;
            r_size     <= n_size;
            r_addr     <= n_addr;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_ok        <= n_ok;
            r_form      <= n_form;
            r_out_major <= (n_form != sepc_pkg::FORM_NONE) ? n_major : 8'd0;
            r_out_minor <= (n_form != sepc_pkg::FORM_NONE) ? n_minor : 8'd0;
            r_out_size  <= (n_form != sepc_pkg::FORM_NONE) ? n_size : 32'd0;
            r_out_addr  <= (n_form != sepc_pkg::FORM_NONE) ? n_addr : 64'd0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_entry_ok      = r_ok;
    assign o_entry_form    = r_form;
    assign o_spec_major    = r_out_major;
    assign o_spec_minor    = r_out_minor;
    assign o_table_size    = r_out_size;
    assign o_table_address = r_out_addr;

    a_final_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.last) |=> r_out_valid)
        else $error("final byte did not produce a result");

    a_no_form_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_form == sepc_pkg::FORM_NONE)
        |-> (!r_ok && r_out_size == '0 && r_out_addr == '0))
        else $error("result without signature carries data");

    a_ok_needs_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ok) |-> (r_out_size != '0 && r_out_addr != '0))
        else $error("ok result with zero table fields");

endmodule

// ===== hw/rtl/smbios_entry_point_check_core.sv =====
// Top level of the SMBIOS entry point checker: front end, request queue and back end.
// Throughput: one byte request per cycle, also across candidates, unless a held result stalls.
// Result path: the edge that accepts the final byte writes it into the queue; the back end
// then runs the checks and capture and registers the result at the edge that pops that byte.
// A held result blocks a final byte at the queue head and every byte queued behind it.
// Reset (synchronous, active low) empties the queue, clears the byte index and the result valid.
module smbios_entry_point_check_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_entry_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_entry_ok,
    output logic [1:0]  o_entry_form,
    output logic [7:0]  o_spec_major,
    output logic [7:0]  o_spec_minor,
    output logic [31:0] o_table_size,
    output logic [63:0] o_table_address
);

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_q_valid;
    sepc_pkg::t_item  w_item;
    sepc_pkg::t_item  w_head;

    // Accept and classify
    sepc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_entry_byte (i_entry_byte),
        .i_last_byte  (i_last_byte),
        .i_full       (w_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_item       (w_item)
    );

    // Decoupling queue
    sepc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // Checks and result
    sepc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_entry_ok      (o_entry_ok),
        .o_entry_form    (o_entry_form),
        .o_spec_major    (o_spec_major),
        .o_spec_minor    (o_spec_minor),
        .o_table_size    (o_table_size),
        .o_table_address (o_table_address)
    );

endmodule
